[rtl/aop_pkg.sv]
// ----------------------------------------------------------------------------
// aop_pkg
// shared types, constants and helper functions for the asian option path
// payoff core
// ----------------------------------------------------------------------------
`default_nettype none

package aop_pkg;

    localparam int MAX_STEPS = 1024;
    localparam int COUNT_W = 11;
    localparam int SUM_W = 48;
    localparam int DIV_STEPS = SUM_W;
    localparam int EXP_TERMS = 12;

    localparam logic [27:0] LN2_Q28 = 28'd186065279;
    localparam logic [28:0] ONE_Q28 = 29'd268435456;
    localparam logic [34:0] RANGE_OFFSET = 35'd4465566696;
    localparam logic [12:0] LN2_RECIP = 13'd5909;
    localparam logic [31:0] DISC_ONE = 32'h8000_0000;
    localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

    localparam logic [2:0] REG_INITIAL_PRICE = 3'd0;
    localparam logic [2:0] REG_STRIKE_PRICE = 3'd1;
    localparam logic [2:0] REG_OPTION_KIND = 3'd2;
    localparam logic [2:0] REG_DISCOUNT_FACTOR = 3'd3;
    localparam logic [2:0] REG_ANTITHETIC_ON = 3'd4;
    localparam logic [2:0] REG_INCLUDE_START = 3'd5;

    localparam logic [1:0] KIND_CALL = 2'd0;
    localparam logic [1:0] KIND_PUT = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_RANGE1,
        S_RANGE2,
        S_TERM_A,
        S_TERM_B,
        S_TERM_C,
        S_GROW1,
        S_GROW2,
        S_FINISH,
        S_DIV_INIT,
        S_DIV_RUN,
        S_DIV_DONE,
        S_PAY,
        S_DISC,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_SET_OVF,
        OP_RANGE1,
        OP_RANGE2,
        OP_TERM_A,
        OP_TERM_B,
        OP_TERM_C,
        OP_GROW1,
        OP_GROW2,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_PAY,
        OP_DISC,
        OP_LOAD_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       side;
        logic [3:0] term;
    } cmd_t;

    typedef struct packed {
        logic limit_ok;
        logic last;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [31:0] initial_price;
        logic [31:0] strike_price;
        logic [1:0]  option_kind;
        logic [31:0] discount_factor;
        logic        antithetic_on;
        logic        include_start_fixing;
    } cfg_t;

    // floor(2^32 / i) for the series term divisors
    function automatic logic [32:0] term_recip(input logic [3:0] i);
        logic [32:0] r;
        case (i)
            4'd1:    r = 33'd4294967296;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/asian_option_path_payoff_core.sv]
// ----------------------------------------------------------------------------
// asian_option_path_payoff_core
// arithmetic average asian option payoff of one monte carlo path, fed one
// log step at a time, with optional antithetic twin path
//
// input channel: in_valid / in_stall carry drift_step, diffusion_step and
// last_step; a request is taken when in_valid is high and in_stall low.
// output channel: out_valid / out_stall carry option_value and saturated,
// one request per path, after the request marked last_step.
// config: cfg_we writes cfg_data into the register picked by cfg_index
// (0 initial price, 1 strike, 2 kind, 3 discount, 4 antithetic, 5 start fixing)
// each step runs the exp series unit over 12 terms for each of the two paths,
// and in_stall stays high until the step is done. a last step adds two
// averaging divides, payoff and discount before option_value shows.
// a step beyond the path length limit skips the update and flags saturation.
// reset clears the sequencer, the path state and out_valid; config
// registers return to their defaults. a stalled output holds; the next step
// is taken meanwhile, and the core waits only when a new value is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module asian_option_path_payoff_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] drift_step,
    input  wire logic [31:0] diffusion_step,
    input  wire logic        last_step,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      option_value,
    output logic             saturated,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    aop_pkg::cfg_t    cfg_reg;
    aop_pkg::cmd_t    cmd;
    aop_pkg::status_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_price        <= 32'd6553600;
            cfg_reg.strike_price         <= 32'd6553600;
            cfg_reg.option_kind          <= aop_pkg::KIND_CALL;
            cfg_reg.discount_factor      <= aop_pkg::DISC_ONE;
            cfg_reg.antithetic_on        <= 1'b0;
            cfg_reg.include_start_fixing <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aop_pkg::REG_INITIAL_PRICE:   cfg_reg.initial_price <= cfg_data;
                aop_pkg::REG_STRIKE_PRICE:    cfg_reg.strike_price <= cfg_data;
                aop_pkg::REG_OPTION_KIND:     cfg_reg.option_kind <= cfg_data[1:0];
                aop_pkg::REG_DISCOUNT_FACTOR: cfg_reg.discount_factor <= cfg_data;
                aop_pkg::REG_ANTITHETIC_ON:   cfg_reg.antithetic_on <= cfg_data[0];
                aop_pkg::REG_INCLUDE_START:   cfg_reg.include_start_fixing <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    aop_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    aop_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .sts            (sts),
        .drift_step     (drift_step),
        .diffusion_step (diffusion_step),
        .last_step      (last_step),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .option_value   (option_value),
        .saturated      (saturated)
    );

endmodule

`default_nettype wire

[rtl/aop_ctrl.sv]
// ----------------------------------------------------------------------------
// aop_ctrl
// sequencer for the path payoff core: steps the datapath through the range
// reduction, exp series, price update, averaging divide and discount
// ----------------------------------------------------------------------------
`default_nettype none

module aop_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire aop_pkg::status_t sts,
    output aop_pkg::cmd_t       cmd
);

    aop_pkg::state_t state_reg, state_next;
    logic            side_reg, side_next;
    logic [3:0]      term_reg, term_next;
    logic [5:0]      bit_reg, bit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aop_pkg::S_IDLE;
            side_reg  <= 1'b0;
            term_reg  <= 4'd1;
            bit_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
            term_reg  <= term_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        term_next  = term_reg;
        bit_next   = bit_reg;
        in_stall   = 1'b1;
        cmd.op     = aop_pkg::OP_NONE;
        cmd.side   = side_reg;
        cmd.term   = term_reg;
        case (state_reg)
            aop_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = aop_pkg::OP_ACCEPT;
                    state_next = aop_pkg::S_CHECK;
                end
            end
            aop_pkg::S_CHECK:
            begin
                side_next = 1'b0;
                if (sts.limit_ok)
                begin
                    state_next = aop_pkg::S_RANGE1;
                end
                else
                begin
                    cmd.op     = aop_pkg::OP_SET_OVF;
                    state_next = aop_pkg::S_FINISH;
                end
            end
            aop_pkg::S_RANGE1:
            begin
                cmd.op     = aop_pkg::OP_RANGE1;
                state_next = aop_pkg::S_RANGE2;
            end
            aop_pkg::S_RANGE2:
            begin
                cmd.op     = aop_pkg::OP_RANGE2;
                term_next  = 4'd1;
                state_next = aop_pkg::S_TERM_A;
            end
            aop_pkg::S_TERM_A:
            begin
                cmd.op     = aop_pkg::OP_TERM_A;
                state_next = aop_pkg::S_TERM_B;
            end
            aop_pkg::S_TERM_B:
            begin
                cmd.op     = aop_pkg::OP_TERM_B;
                state_next = aop_pkg::S_TERM_C;
            end
            aop_pkg::S_TERM_C:
            begin
                cmd.op = aop_pkg::OP_TERM_C;
                if (term_reg == 4'(aop_pkg::EXP_TERMS))
                begin
                    state_next = aop_pkg::S_GROW1;
                end
                else
                begin
                    term_next  = term_reg + 4'd1;
                    state_next = aop_pkg::S_TERM_A;
                end
            end
            aop_pkg::S_GROW1:
            begin
                cmd.op     = aop_pkg::OP_GROW1;
                state_next = aop_pkg::S_GROW2;
            end
            aop_pkg::S_GROW2:
            begin
                cmd.op = aop_pkg::OP_GROW2;
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    state_next = aop_pkg::S_RANGE1;
                end
                else
                begin
                    state_next = aop_pkg::S_FINISH;
                end
            end
            aop_pkg::S_FINISH:
            begin
                side_next  = 1'b0;
                state_next = sts.last ? aop_pkg::S_DIV_INIT : aop_pkg::S_IDLE;
            end
            aop_pkg::S_DIV_INIT:
            begin
                cmd.op     = aop_pkg::OP_DIV_INIT;
                bit_next   = 6'd0;
                state_next = aop_pkg::S_DIV_RUN;
            end
            aop_pkg::S_DIV_RUN:
            begin
                cmd.op = aop_pkg::OP_DIV_STEP;
                if (bit_reg == 6'(aop_pkg::DIV_STEPS - 1))
                begin
                    state_next = aop_pkg::S_DIV_DONE;
                end
                else
                begin
                    bit_next = bit_reg + 6'd1;
                end
            end
            aop_pkg::S_DIV_DONE:
            begin
                cmd.op = aop_pkg::OP_DIV_DONE;
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    state_next = aop_pkg::S_DIV_INIT;
                end
                else
                begin
                    state_next = aop_pkg::S_PAY;
                end
            end
            aop_pkg::S_PAY:
            begin
                cmd.op     = aop_pkg::OP_PAY;
                state_next = aop_pkg::S_DISC;
            end
            aop_pkg::S_DISC:
            begin
                cmd.op     = aop_pkg::OP_DISC;
                state_next = aop_pkg::S_OUT;
            end
            aop_pkg::S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = aop_pkg::OP_LOAD_OUT;
                    state_next = aop_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = aop_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/aop_dp.sv]
// ----------------------------------------------------------------------------
// aop_dp
// datapath: path state, exp series unit, price and sum update, averaging
// divider, payoff, discount and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module aop_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire aop_pkg::cfg_t  cfg,
    input  wire aop_pkg::cmd_t  cmd,
    output aop_pkg::status_t    sts,
    input  wire logic [31:0]    drift_step,
    input  wire logic [31:0]    diffusion_step,
    input  wire logic           last_step,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [31:0]         option_value,
    output logic                saturated
);

    // control state
    logic                      active_reg;
    logic                      ovf_reg;
    logic                      ovfp_reg;
    logic                      start_fixed_reg;
    logic [aop_pkg::COUNT_W-1:0] count_reg;
    logic                      out_valid_reg;

    // payload
    logic [31:0] drift_reg, diff_reg;
    logic        last_reg;
    logic [31:0] price_p_reg, price_m_reg;
    logic [47:0] sum_p_reg, sum_m_reg;
    logic [33:0] xo_reg;
    logic [46:0] qprod_reg;
    logic [27:0] r_reg;
    logic [6:0]  k_reg;
    logic [28:0] t_reg;
    logic [29:0] e_reg;
    logic [56:0] prod_reg;
    logic [28:0] p_reg;
    logic [28:0] qe_reg;
    logic [32:0] m_reg;
    logic [10:0] rem_reg;
    logic [47:0] quo_reg;
    logic [31:0] pay_p_reg, pay_m_reg;
    logic [32:0] pay_reg;
    logic [31:0] dcl_reg;
    logic [64:0] disc_reg;
    logic [31:0] value_reg;
    logic        sat_reg;

    // range reduction
    logic [32:0] x;
    logic [34:0] xo;
    logic [46:0] qprod_next;
    logic [6:0]  q_est;
    logic [34:0] qel;
    logic [34:0] rr;
    logic        r_hi;
    logic [27:0] r_next;
    logic [6:0]  q_fix;

    // series term
    logic [61:0] qe_prod;
    logic [32:0] qi;
    logic [28:0] trem;
    logic [28:0] qf;

    // price update
    logic [31:0] price_cur;
    logic [47:0] sum_cur;
    logic [63:0] m_prod;
    logic [55:0] shl;
    logic [4:0]  nk;
    logic [32:0] shr;
    logic        p_ovf;
    logic [31:0] price_next;
    logic [48:0] sum_add;
    logic        s_ovf;
    logic [47:0] sum_next;
    logic        step_ovf;

    // divider and payoff
    logic [11:0] rs;
    logic        ge;
    logic [11:0] rs_sub;
    logic [31:0] avg;
    logic [31:0] payoff;

    assign x = cmd.side ? ({drift_reg[31], drift_reg} - {diff_reg[31], diff_reg})
                        : ({drift_reg[31], drift_reg} + {diff_reg[31], diff_reg});
    assign xo = {{2{x[32]}}, x} + aop_pkg::RANGE_OFFSET;
    assign qprod_next = 47'(xo[33:0]) * 47'(aop_pkg::LN2_RECIP);
    assign q_est = qprod_reg[46:40];
    assign qel = 35'(q_est) * 35'(aop_pkg::LN2_Q28);
    assign rr = 35'(xo_reg) - qel;
    assign r_hi = rr >= 35'(aop_pkg::LN2_Q28);
    assign r_next = r_hi ? 28'(rr - 35'(aop_pkg::LN2_Q28)) : rr[27:0];
    assign q_fix = q_est + 7'(r_hi);

    assign qe_prod = 62'(prod_reg[56:28]) * 62'(aop_pkg::term_recip(cmd.term));
    assign qi = 33'(qe_reg) * 33'(cmd.term);
    assign trem = p_reg - qi[28:0];
    assign qf = qe_reg + 29'(trem >= 29'(cmd.term));

    assign price_cur = cmd.side ? price_m_reg : price_p_reg;
    assign sum_cur = cmd.side ? sum_m_reg : sum_p_reg;
    assign m_prod = 64'(price_cur) * 64'(e_reg);
    assign shl = 56'(m_reg) << k_reg[4:0];
    assign nk = 5'(7'd0 - k_reg);
    assign shr = m_reg >> nk;
    assign p_ovf = !k_reg[6] && (shl[55:32] != 24'd0);
    assign price_next = p_ovf ? aop_pkg::PRICE_MAX
                      : (k_reg[6] ? shr[31:0] : shl[31:0]);
    assign sum_add = 49'(sum_cur) + 49'(price_next);
    assign s_ovf = sum_add[48];
    assign sum_next = s_ovf ? 48'hFFFF_FFFF_FFFF : sum_add[47:0];
    assign step_ovf = p_ovf || s_ovf;

    assign rs = {rem_reg, quo_reg[47]};
    assign ge = rs >= {1'b0, count_reg};
    assign rs_sub = rs - {1'b0, count_reg};
    assign avg = (count_reg == '0) ? 32'd0
               : ((quo_reg[47:32] != 16'd0) ? aop_pkg::PRICE_MAX : quo_reg[31:0]);

    always_comb
    begin
        case (cfg.option_kind)
            aop_pkg::KIND_CALL:
                payoff = (avg > cfg.strike_price) ? avg - cfg.strike_price : 32'd0;
            aop_pkg::KIND_PUT:
                payoff = (cfg.strike_price > avg) ? cfg.strike_price - avg : 32'd0;
            default:
                payoff = (avg > cfg.strike_price) ? avg - cfg.strike_price
                                                  : cfg.strike_price - avg;
        endcase
    end

    assign sts.limit_ok = count_reg < (11'(aop_pkg::MAX_STEPS) + 11'(start_fixed_reg));
    assign sts.last = last_reg;
    assign sts.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            ovf_reg         <= 1'b0;
            ovfp_reg        <= 1'b0;
            start_fixed_reg <= 1'b0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if ((cmd.op != aop_pkg::OP_LOAD_OUT) && out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                aop_pkg::OP_ACCEPT:
                begin
                    if (!active_reg)
                    begin
                        active_reg      <= 1'b1;
                        ovf_reg         <= 1'b0;
                        start_fixed_reg <= cfg.include_start_fixing;
                        count_reg       <= 11'(cfg.include_start_fixing);
                    end
                end
                aop_pkg::OP_SET_OVF:
                begin
                    ovf_reg <= 1'b1;
                end
                aop_pkg::OP_GROW2:
                begin
                    if (!cmd.side)
                    begin
                        ovfp_reg <= step_ovf;
                    end
                    else
                    begin
                        ovf_reg   <= ovf_reg || ovfp_reg || (cfg.antithetic_on && step_ovf);
                        count_reg <= count_reg + 11'd1;
                    end
                end
                aop_pkg::OP_LOAD_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    active_reg    <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            aop_pkg::OP_ACCEPT:
            begin
                drift_reg <= drift_step;
                diff_reg  <= diffusion_step;
                last_reg  <= last_step;
                if (!active_reg)
                begin
                    price_p_reg <= cfg.initial_price;
                    price_m_reg <= cfg.initial_price;
                    sum_p_reg   <= cfg.include_start_fixing ? 48'(cfg.initial_price) : 48'd0;
                    sum_m_reg   <= cfg.include_start_fixing ? 48'(cfg.initial_price) : 48'd0;
                end
            end
            aop_pkg::OP_RANGE1:
            begin
                xo_reg    <= xo[33:0];
                qprod_reg <= qprod_next;
            end
            aop_pkg::OP_RANGE2:
            begin
                r_reg <= r_next;
                k_reg <= q_fix - 7'd24;
                t_reg <= aop_pkg::ONE_Q28;
                e_reg <= 30'(aop_pkg::ONE_Q28);
            end
            aop_pkg::OP_TERM_A:
            begin
                prod_reg <= 57'(t_reg) * 57'(r_reg);
            end
            aop_pkg::OP_TERM_B:
            begin
                p_reg  <= prod_reg[56:28];
                qe_reg <= qe_prod[60:32];
            end
            aop_pkg::OP_TERM_C:
            begin
                t_reg <= qf;
                e_reg <= e_reg + 30'(qf);
            end
            aop_pkg::OP_GROW1:
            begin
                m_reg <= m_prod[60:28];
            end
            aop_pkg::OP_GROW2:
            begin
                if (cmd.side)
                begin
                    price_m_reg <= price_next;
                    sum_m_reg   <= sum_next;
                end
                else
                begin
                    price_p_reg <= price_next;
                    sum_p_reg   <= sum_next;
                end
            end
            aop_pkg::OP_DIV_INIT:
            begin
                quo_reg <= cmd.side ? sum_m_reg : sum_p_reg;
                rem_reg <= 11'd0;
            end
            aop_pkg::OP_DIV_STEP:
            begin
                rem_reg <= ge ? rs_sub[10:0] : rs[10:0];
                quo_reg <= {quo_reg[46:0], ge};
            end
            aop_pkg::OP_DIV_DONE:
            begin
                if (cmd.side)
                begin
                    pay_m_reg <= payoff;
                end
                else
                begin
                    pay_p_reg <= payoff;
                end
            end
            aop_pkg::OP_PAY:
            begin
                pay_reg <= cfg.antithetic_on ? 33'(pay_p_reg) + 33'(pay_m_reg)
                                             : 33'(pay_p_reg);
                dcl_reg <= (cfg.discount_factor > aop_pkg::DISC_ONE)
                         ? aop_pkg::DISC_ONE : cfg.discount_factor;
            end
            aop_pkg::OP_DISC:
            begin
                disc_reg <= 65'(pay_reg) * 65'(dcl_reg);
            end
            aop_pkg::OP_LOAD_OUT:
            begin
                value_reg <= cfg.antithetic_on ? disc_reg[63:32] : disc_reg[62:31];
                sat_reg   <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign option_value = value_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire
